// File: hw/rtl/deque_sort_dedup_engine_macros.svh
// assertion macros for the deque sort dedup engine checker
// expects signals clk and arst_n in the scope of each use
`ifndef DEQUE_SORT_DEDUP_ENGINE_MACROS_SVH
`define DEQUE_SORT_DEDUP_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DSDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dsde_pkg.sv
// shared types and codes of the deque sort dedup engine
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package dsde_pkg;

	// command codes on the mode field
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_LIST       = 3'd4;
	localparam logic [2:0] MODE_SORT       = 3'd5;
	localparam logic [2:0] MODE_DEDUPE     = 3'd6;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LIST_RD,
		ST_LIST_OUT,
		ST_SORT_PASS,
		ST_SORT_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_END,
		ST_DD_RD,
		ST_DD_LOAD,
		ST_DD_SCAN,
		ST_DD_CMP,
		ST_DD_KEEP,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_EXEC,
		OP_WALK_INIT,
		OP_RD_IDX,
		OP_RD_SCAN,
		OP_LIST_EMIT,
		OP_SORT_LOAD,
		OP_SORT_CMP,
		OP_SORT_END,
		OP_DD_LOAD,
		OP_DD_CMP,
		OP_DD_KEEP,
		OP_FINISH
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       empty;
		logic       out_free;
		logic       list_last;
		logic       end_le1;
		logic       last_pair;
		logic       walk_done;
		logic       scan_done;
		logic       seen;
	} dp_stat_t;

endpackage

// File: hw/rtl/dsde_ctrl.sv
// controller state machine of the deque sort dedup engine
// depends on dsde_pkg; drives commands into dsde_dpath
`timescale 1ns / 1ps

module dsde_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dsde_pkg::dp_stat_t stat,
	output dsde_pkg::dp_cmd_t  cmd
);

	dsde_pkg::state_t state_q, state_d;
	logic walk_mode;

	assign walk_mode = (stat.mode == dsde_pkg::MODE_LIST) ||
		(stat.mode == dsde_pkg::MODE_SORT) || (stat.mode == dsde_pkg::MODE_DEDUPE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsde_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = dsde_pkg::OP_NONE;
		cmd.emit = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			dsde_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = dsde_pkg::OP_CAPTURE;
					state_d = dsde_pkg::ST_EXEC;
				end
			end
			dsde_pkg::ST_EXEC: begin
				if (walk_mode && !stat.empty) begin
					cmd.op = dsde_pkg::OP_WALK_INIT;
					priority if (stat.mode == dsde_pkg::MODE_LIST) begin
						state_d = dsde_pkg::ST_LIST_RD;
					end else if (stat.mode == dsde_pkg::MODE_SORT) begin
						state_d = dsde_pkg::ST_SORT_PASS;
					end else begin
						state_d = dsde_pkg::ST_DD_RD;
					end
				end else if (stat.out_free) begin
					cmd.op   = dsde_pkg::OP_EXEC;
					cmd.emit = 1'b1;
					state_d  = dsde_pkg::ST_IDLE;
				end
			end
			dsde_pkg::ST_LIST_RD: begin
				cmd.op  = dsde_pkg::OP_RD_IDX;
				state_d = dsde_pkg::ST_LIST_OUT;
			end
			dsde_pkg::ST_LIST_OUT: begin
				if (stat.out_free) begin
					cmd.op   = dsde_pkg::OP_LIST_EMIT;
					cmd.emit = 1'b1;
					state_d  = stat.list_last ? dsde_pkg::ST_IDLE : dsde_pkg::ST_LIST_RD;
				end
			end
			dsde_pkg::ST_SORT_PASS: begin
				if (stat.end_le1) begin
					state_d = dsde_pkg::ST_FINISH;
				end else begin
					cmd.op  = dsde_pkg::OP_RD_IDX;
					state_d = dsde_pkg::ST_SORT_LOAD;
				end
			end
			dsde_pkg::ST_SORT_LOAD: begin
				cmd.op  = dsde_pkg::OP_SORT_LOAD;
				state_d = dsde_pkg::ST_SORT_RD;
			end
			dsde_pkg::ST_SORT_RD: begin
				cmd.op  = dsde_pkg::OP_RD_IDX;
				state_d = dsde_pkg::ST_SORT_CMP;
			end
			dsde_pkg::ST_SORT_CMP: begin
				cmd.op  = dsde_pkg::OP_SORT_CMP;
				state_d = stat.last_pair ? dsde_pkg::ST_SORT_END : dsde_pkg::ST_SORT_RD;
			end
			dsde_pkg::ST_SORT_END: begin
				cmd.op  = dsde_pkg::OP_SORT_END;
				state_d = dsde_pkg::ST_SORT_PASS;
			end
			dsde_pkg::ST_DD_RD: begin
				if (stat.walk_done) begin
					state_d = dsde_pkg::ST_FINISH;
				end else begin
					cmd.op  = dsde_pkg::OP_RD_IDX;
					state_d = dsde_pkg::ST_DD_LOAD;
				end
			end
			dsde_pkg::ST_DD_LOAD: begin
				cmd.op  = dsde_pkg::OP_DD_LOAD;
				state_d = dsde_pkg::ST_DD_SCAN;
			end
			dsde_pkg::ST_DD_SCAN: begin
				if (stat.seen || stat.scan_done) begin
					state_d = dsde_pkg::ST_DD_KEEP;
				end else begin
					cmd.op  = dsde_pkg::OP_RD_SCAN;
					state_d = dsde_pkg::ST_DD_CMP;
				end
			end
			dsde_pkg::ST_DD_CMP: begin
				cmd.op  = dsde_pkg::OP_DD_CMP;
				state_d = dsde_pkg::ST_DD_SCAN;
			end
			dsde_pkg::ST_DD_KEEP: begin
				cmd.op  = dsde_pkg::OP_DD_KEEP;
				state_d = dsde_pkg::ST_DD_RD;
			end
			dsde_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.op   = dsde_pkg::OP_FINISH;
					cmd.emit = 1'b1;
					state_d  = dsde_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsde_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/dsde_dpath.sv
// datapath of the deque sort dedup engine: store, pointers, walk counters, result register
// depends on dsde_pkg; driven by dsde_ctrl
`timescale 1ns / 1ps

module dsde_dpath #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          mode,
	input  logic signed [31:0]  value,
	input  dsde_pkg::dp_cmd_t   cmd,
	output dsde_pkg::dp_stat_t  stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [31:0]  element,
	output logic [1:0]          status,
	output logic [5:0]          occupancy,
	output logic                last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);

	logic signed [DATA_WIDTH-1:0] mem [CAPACITY];
	logic signed [DATA_WIDTH-1:0] rdata_q, carry_q, cand_q, wdata, val_ext;

	logic [2:0]         mode_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      front_q, front_n, front_dec, front_inc;
	logic [AW-1:0]      rd_addr_q, wr_addr_q, waddr, raddr, slot_addr;
	logic [AW:0]        slot_sum;
	logic [PW-1:0]      count_q, count_n, count_fin, idx_q, end_q, kept_q, scan_q, pos;
	logic               seen_q, we, re, push_we, full, empty, less, list_last, out_free;
	logic [1:0]         exec_status;

	logic               out_valid_q, last_q;
	logic signed [31:0] element_q;
	logic [1:0]         status_q;
	logic [5:0]         occ_q;

	assign val_ext   = DATA_WIDTH'(val_q);
	assign full      = (count_q == PW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign less      = (rdata_q < carry_q);
	assign list_last = ((idx_q + PW'(1)) == count_q);
	assign out_free  = !out_valid_q || out_ready;
	assign count_fin = (mode_q == dsde_pkg::MODE_DEDUPE) ? kept_q : count_q;

	// circular slot of a queue position
	assign slot_sum  = (AW+1)'(front_q) + (AW+1)'(pos);
	assign slot_addr = (slot_sum >= (AW+1)'(CAPACITY)) ?
		AW'(slot_sum - (AW+1)'(CAPACITY)) : AW'(slot_sum);
	assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		unique case (cmd.op)
			dsde_pkg::OP_RD_SCAN: pos = scan_q;
			dsde_pkg::OP_DD_KEEP: pos = kept_q;
			dsde_pkg::OP_EXEC:    pos = count_q;
			default:              pos = idx_q;
		endcase
	end

	// push and pop
	always_comb begin
		count_n     = count_q;
		front_n     = front_q;
		exec_status = dsde_pkg::STATUS_OK;
		push_we     = 1'b0;
		unique case (mode_q)
			dsde_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					exec_status = dsde_pkg::STATUS_FULL;
				end else begin
					front_n = front_dec;
					count_n = count_q + 1'b1;
					push_we = 1'b1;
				end
			end
			dsde_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					exec_status = dsde_pkg::STATUS_FULL;
				end else begin
					count_n = count_q + 1'b1;
					push_we = 1'b1;
				end
			end
			dsde_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					exec_status = dsde_pkg::STATUS_EMPTY;
				end else begin
					front_n = front_inc;
					count_n = count_q - 1'b1;
				end
			end
			dsde_pkg::MODE_POP_BACK: begin
				if (empty) begin
					exec_status = dsde_pkg::STATUS_EMPTY;
				end else begin
					count_n = count_q - 1'b1;
				end
			end
			dsde_pkg::MODE_LIST, dsde_pkg::MODE_SORT, dsde_pkg::MODE_DEDUPE: begin
				exec_status = empty ? dsde_pkg::STATUS_EMPTY : dsde_pkg::STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	// store port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = slot_addr;
		raddr = slot_addr;
		wdata = val_ext;
		unique case (cmd.op)
			dsde_pkg::OP_EXEC: begin
				we    = push_we;
				waddr = (mode_q == dsde_pkg::MODE_PUSH_FRONT) ? front_dec : slot_addr;
			end
			dsde_pkg::OP_RD_IDX, dsde_pkg::OP_RD_SCAN: begin
				re = 1'b1;
			end
			dsde_pkg::OP_SORT_CMP: begin
				we    = 1'b1;
				waddr = wr_addr_q;
				wdata = less ? rdata_q : carry_q;
			end
			dsde_pkg::OP_SORT_END: begin
				we    = 1'b1;
				waddr = wr_addr_q;
				wdata = carry_q;
			end
			dsde_pkg::OP_DD_KEEP: begin
				we    = !seen_q;
				wdata = cand_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q   <= mem[raddr];
			rd_addr_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			end_q       <= '0;
			kept_q      <= '0;
			scan_q      <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				dsde_pkg::OP_EXEC: begin
					front_q <= front_n;
					count_q <= count_n;
				end
				dsde_pkg::OP_WALK_INIT: begin
					idx_q  <= '0;
					kept_q <= '0;
					end_q  <= count_q;
				end
				dsde_pkg::OP_LIST_EMIT, dsde_pkg::OP_SORT_CMP: begin
					idx_q <= idx_q + 1'b1;
				end
				dsde_pkg::OP_SORT_LOAD: begin
					idx_q <= PW'(1);
				end
				dsde_pkg::OP_SORT_END: begin
					end_q <= end_q - 1'b1;
					idx_q <= '0;
				end
				dsde_pkg::OP_DD_LOAD: begin
					scan_q <= '0;
					seen_q <= 1'b0;
				end
				dsde_pkg::OP_DD_CMP: begin
					seen_q <= (rdata_q == cand_q);
					scan_q <= scan_q + 1'b1;
				end
				dsde_pkg::OP_DD_KEEP: begin
					if (!seen_q) begin
						kept_q <= kept_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				dsde_pkg::OP_FINISH: begin
					count_q <= count_fin;
				end
				default: begin
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			dsde_pkg::OP_CAPTURE: begin
				mode_q <= mode;
				val_q  <= value;
			end
			dsde_pkg::OP_SORT_LOAD: begin
				carry_q   <= rdata_q;
				wr_addr_q <= rd_addr_q;
			end
			dsde_pkg::OP_SORT_CMP: begin
				if (!less) begin
					carry_q <= rdata_q;
				end
				wr_addr_q <= rd_addr_q;
			end
			dsde_pkg::OP_DD_LOAD: begin
				cand_q <= rdata_q;
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			element_q <= (cmd.op == dsde_pkg::OP_LIST_EMIT) ? 32'(rdata_q) : '0;
			status_q  <= (cmd.op == dsde_pkg::OP_EXEC) ? exec_status : dsde_pkg::STATUS_OK;
			last_q    <= (cmd.op == dsde_pkg::OP_LIST_EMIT) ? list_last : 1'b1;
			unique case (cmd.op)
				dsde_pkg::OP_EXEC:   occ_q <= 6'(count_n);
				dsde_pkg::OP_FINISH: occ_q <= 6'(count_fin);
				default:             occ_q <= 6'(count_q);
			endcase
		end
	end

	assign stat.mode      = mode_q;
	assign stat.empty     = empty;
	assign stat.out_free  = out_free;
	assign stat.list_last = list_last;
	assign stat.end_le1   = (end_q <= PW'(1));
	assign stat.last_pair = ((idx_q + PW'(1)) == end_q);
	assign stat.walk_done = (idx_q == count_q);
	assign stat.scan_done = (scan_q == kept_q);
	assign stat.seen      = seen_q;

	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign occupancy = occ_q;
	assign last      = last_q;

endmodule

// File: hw/rtl/deque_sort_dedup_engine.sv
// top level of the deque sort dedup engine
// depends on dsde_pkg, dsde_ctrl and dsde_dpath
`timescale 1ns / 1ps

// Bounded double-ended queue of signed values in a single-port circular store of
// CAPACITY words, tracked by a front index and a count. Each input word carries a mode
// and a value; every command returns one result word, except list on a non-empty queue,
// which returns one word per element, front first, with last set on the final one.
// A push, a pop, an unused mode or any command on an empty queue passes through the
// accepting idle state and the execute state, which loads its result into the output
// register. The next word is taken as soon as the controller is back in idle, even
// while that result still waits on out_ready; every load of the output register waits
// until the register is free. list makes one read and one output load per element.
// sort is a bubble sort that carries the running maximum through each pass, and dedupe
// reads each element and then rescans the kept prefix. While list, sort or dedupe run,
// in_ready stays low. The store has no reset; only occupied entries are ever read.
module deque_sort_dedup_engine #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// command words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] element,
	output logic [1:0]         status,
	output logic [5:0]         occupancy,
	output logic               last
);

	// command and status between the state machine and the datapath
	dsde_pkg::dp_cmd_t  cmd;
	dsde_pkg::dp_stat_t stat;

	// sequencer: idle, execute, and the walks for list, sort and dedupe
	dsde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, front and count, walk counters and the output register
	dsde_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.element   (element),
		.status    (status),
		.occupancy (occupancy),
		.last      (last)
	);

endmodule

// File: hw/rtl/dsde_checker.sv
// port-level assertions for the deque sort dedup engine, bound to the top level
// depends on dsde_pkg and deque_sort_dedup_engine_macros.svh
`timescale 1ns / 1ps
`include "deque_sort_dedup_engine_macros.svh"

module dsde_checker #(
	parameter int CAPACITY = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] element,
	input logic [1:0]         status,
	input logic [5:0]         occupancy,
	input logic               last
);

	// a stalled result word holds
	`DSDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(element) && $stable(status) && $stable(occupancy) && $stable(last), "result word changed while stalled")

	// an empty report comes from an empty queue and ends its command
	`DSDE_ASSERT_NOW(a_empty_res, out_valid && status == dsde_pkg::STATUS_EMPTY, occupancy == 6'd0 && last && element == 32'sd0, "empty status with bad payload")

	// a dropped push means the queue is full
	`DSDE_ASSERT_NOW(a_full_occ, out_valid && status == dsde_pkg::STATUS_FULL, occupancy == 6'(CAPACITY), "full status below capacity")

	// words before the last one belong to a list walk, which holds off input
	`DSDE_ASSERT_NOW(a_list_busy, out_valid && !last, status == dsde_pkg::STATUS_OK && !in_ready, "non-final word outside a list walk")

endmodule

bind deque_sort_dedup_engine dsde_checker #(
	.CAPACITY (CAPACITY)
) u_dsde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.element   (element),
	.status    (status),
	.occupancy (occupancy),
	.last      (last)
);
